// ===== rtl/core/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and codes of the round-robin thread scheduler
// Slot status codes, request and error codes, controller states and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int SLOT_W    = 6;
  localparam int MAX_SLOTS = 1 << SLOT_W;

  // Slot status codes
  localparam logic [2:0] ST_RUNNING = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_HANGING = 3'd4;
  localparam logic [2:0] ST_DEAD    = 3'd5;

  // Request codes
  localparam logic [2:0] REQ_CREATE  = 3'd0;
  localparam logic [2:0] REQ_SLICE   = 3'd1;
  localparam logic [2:0] REQ_BLOCK   = 3'd2;
  localparam logic [2:0] REQ_UNBLOCK = 3'd3;
  localparam logic [2:0] REQ_YIELD   = 3'd4;
  localparam logic [2:0] REQ_EXIT    = 3'd5;

  localparam logic [1:0] KIND_BAD = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_STATUS = 2'd1;
  localparam logic [1:0] ERR_NORUN  = 2'd2;

  typedef enum logic [1:0] {
    SCH_NONE,
    SCH_ROT,
    SCH_POP,
    SCH_WAKE
  } sched_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_T,
    S_RD_R,
    S_RD_I,
    S_DEC,
    S_PLAN,
    S_PRE,
    S_RM_RD,
    S_RM_CK,
    S_APP,
    S_QRD,
    S_POP,
    S_WAKE,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic rd_tid;
    logic rd_run;
    logic rd_idle;
    logic cap_t;
    logic cap_r;
    logic dec;
    logic pre;
    logic rm_rd;
    logic rm_ck;
    logic app;
    logic qrd;
    logic pop;
    logic wake;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic   fail;
    logic   pre;
    logic   rm;
    sched_e sched;
    logic   rm_last;
    logic   out_full;
  } stat_t;

endpackage

// ===== rtl/core/rrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrts_ctrl: request sequencer
// Steps one request through status reads, decision, queue walk, scheduling
// and result hand-off.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rrts_pkg::stat_t stat_i,
  output rrts_pkg::cmd_t  cmd_o
);
  import rrts_pkg::*;

  ctrl_state_e state_q, state_d;

  function automatic ctrl_state_e sched_state(sched_e m);
    ctrl_state_e s;
    case (m)
      SCH_ROT:  s = S_APP;
      SCH_POP:  s = S_QRD;
      SCH_WAKE: s = S_WAKE;
      default:  s = S_OUT;
    endcase
    return s;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RD_T;
        end
      end
      S_RD_T: begin
        cmd_o.rd_tid = 1'b1;
        state_d      = S_RD_R;
      end
      S_RD_R: begin
        cmd_o.cap_t  = 1'b1;
        cmd_o.rd_run = 1'b1;
        state_d      = S_RD_I;
      end
      S_RD_I: begin
        cmd_o.cap_r   = 1'b1;
        cmd_o.rd_idle = 1'b1;
        state_d       = S_DEC;
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        state_d   = S_PLAN;
      end
      S_PLAN: begin
        if (stat_i.fail) begin
          state_d = S_OUT;
        end else if (stat_i.pre) begin
          state_d = S_PRE;
        end else begin
          state_d = sched_state(stat_i.sched);
        end
      end
      S_PRE: begin
        cmd_o.pre = 1'b1;
        state_d   = stat_i.rm ? S_RM_RD : sched_state(stat_i.sched);
      end
      S_RM_RD: begin
        cmd_o.rm_rd = 1'b1;
        state_d     = S_RM_CK;
      end
      S_RM_CK: begin
        cmd_o.rm_ck = 1'b1;
        state_d     = stat_i.rm_last ? sched_state(stat_i.sched) : S_RM_RD;
      end
      S_APP: begin
        cmd_o.app = 1'b1;
        state_d   = S_QRD;
      end
      S_QRD: begin
        cmd_o.qrd = 1'b1;
        state_d   = S_POP;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_OUT;
      end
      S_WAKE: begin
        cmd_o.wake = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (!stat_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/rrts_dp.sv =====
// ----------------------------------------------------------------------------
// rrts_dp: scheduler datapath
// Slot status memory, ready deque memory, pointers, decision logic and the
// result register.
// ----------------------------------------------------------------------------
module rrts_dp #(
  parameter int THREAD_SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic [2:0] req_type_i,
  input  logic [5:0] thread_id_i,
  input  logic [1:0] block_kind_i,
  input  logic       need_schedule_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] error_code_o,
  output logic       switched_o,
  output logic [5:0] prev_thread_o,
  output logic [5:0] next_thread_o,
  output logic [6:0] ready_count_o,
  input  rrts_pkg::cmd_t  cmd_i,
  output rrts_pkg::stat_t stat_o
);
  import rrts_pkg::*;

  localparam int NS = (THREAD_SLOTS < MAX_SLOTS) ? THREAD_SLOTS : MAX_SLOTS;
  localparam int AW = $clog2(NS);
  localparam int CW = $clog2(NS + 1);

  typedef struct packed {
    logic [1:0] err;
    logic       sw;
    logic       pre;
    logic       rm;
    sched_e     sched;
  } plan_t;

  // Storage
  logic [2:0]        st_mem [NS];
  logic [NS-1:0]     st_vld_q;
  logic [SLOT_W-1:0] q_mem  [NS];

  logic [2:0]        st_rdata_q;
  logic [SLOT_W-1:0] q_rdata_q;

  logic [SLOT_W-1:0] idle_q;
  logic [SLOT_W-1:0] run_q, run_d;
  logic [AW-1:0]     head_q, head_d;
  logic [CW-1:0]     count_q, count_d;

  logic [2:0]        req_q;
  logic [SLOT_W-1:0] tid_q;
  logic [1:0]        kind_q;
  logic              ns_q;
  logic [SLOT_W-1:0] prev_q;
  logic [2:0]        s_t_q, s_r_q;
  plan_t             plan_q, plan_d;

  logic [CW-1:0]     j_q, j_d;
  logic              found_q, found_d;
  logic [AW-1:0]     ppos_q, ppos_d;

  logic              out_valid_q;
  logic [1:0]        out_err_q;
  logic              out_sw_q;
  logic [SLOT_W-1:0] out_prev_q, out_next_q;
  logic [6:0]        out_cnt_q;

  // Memory ports
  logic              st_re, st_we, q_re, q_we;
  logic [AW-1:0]     st_raddr, st_waddr, q_raddr, q_waddr;
  logic [2:0]        st_wdata;
  logic [SLOT_W-1:0] q_wdata;

  function automatic logic [AW-1:0] wrap(logic [AW:0] s);
    logic [AW:0] r;
    r = (s >= (AW+1)'(NS)) ? s - (AW+1)'(NS) : s;
    return r[AW-1:0];
  endfunction

  function automatic logic blockedish(logic [2:0] s);
    return (s >= ST_BLOCKED) && (s <= ST_HANGING);
  endfunction

  logic [AW-1:0] pos_j, tail, head_inc, head_dec;
  assign pos_j    = wrap({1'b0, head_q} + (AW+1)'(j_q));
  assign tail     = wrap({1'b0, head_q} + (AW+1)'(count_q));
  assign head_inc = wrap({1'b0, head_q} + (AW+1)'(1));
  assign head_dec = (head_q == '0) ? AW'(NS - 1) : head_q - 1'b1;

  // Decision over the three captured statuses
  logic       is_create, is_block, is_unblock, is_exit, is_sched;
  logic       tid_ok, idle_ok, err1, do_sched, rm, wake_ok;
  logic [2:0] blk_st, cur_st, idl_st;
  logic [CW-1:0] cnt_after;

  always_comb begin
    is_create  = (req_q == REQ_CREATE);
    is_block   = (req_q == REQ_BLOCK);
    is_unblock = (req_q == REQ_UNBLOCK);
    is_exit    = (req_q == REQ_EXIT);
    is_sched   = (req_q == REQ_SLICE) || (req_q == REQ_YIELD);
    tid_ok     = 32'(tid_q) < 32'(THREAD_SLOTS);
    idle_ok    = 32'(idle_q) < 32'(THREAD_SLOTS);
    blk_st     = ST_BLOCKED + {1'b0, kind_q};

    err1 = (is_create  && (!tid_ok || s_t_q != ST_DEAD))
        || (is_block   && (kind_q == KIND_BAD || s_r_q != ST_RUNNING))
        || (is_unblock && (!tid_ok || !blockedish(s_t_q)))
        || (is_exit    && (!tid_ok || s_t_q == ST_DEAD));

    do_sched = is_sched || is_block || (is_exit && ns_q);
    rm       = is_exit && (s_t_q == ST_READY);
    cnt_after = count_q - CW'(rm);

    if (is_block) begin
      cur_st = blk_st;
    end else if (is_exit && tid_q == run_q) begin
      cur_st = ST_DEAD;
    end else begin
      cur_st = s_r_q;
    end
    if (is_block && idle_q == run_q) begin
      idl_st = blk_st;
    end else if (is_exit && idle_q == tid_q) begin
      idl_st = ST_DEAD;
    end else begin
      idl_st = st_rdata_q;
    end
    wake_ok = idle_ok && blockedish(idl_st);

    plan_d       = plan_q;
    plan_d.err   = ERR_OK;
    plan_d.sched = SCH_NONE;
    if (do_sched) begin
      if (cur_st == ST_RUNNING) begin
        plan_d.sched = (cnt_after == '0) ? SCH_NONE : SCH_ROT;
      end else if (cnt_after != '0) begin
        plan_d.sched = SCH_POP;
      end else if (wake_ok) begin
        plan_d.sched = SCH_WAKE;
      end else begin
        plan_d.err = ERR_NORUN;
      end
    end
    if (err1) begin
      plan_d.err   = ERR_STATUS;
      plan_d.sched = SCH_NONE;
    end
    plan_d.sw  = do_sched && (plan_d.err == ERR_OK);
    plan_d.pre = (plan_d.err == ERR_OK) && (is_create || is_unblock || is_block || is_exit);
    plan_d.rm  = rm;
  end

  assign stat_o.fail     = (plan_q.err != ERR_OK);
  assign stat_o.pre      = plan_q.pre;
  assign stat_o.rm       = plan_q.rm;
  assign stat_o.sched    = plan_q.sched;
  assign stat_o.rm_last  = ((j_q + 1'b1) == count_q);
  assign stat_o.out_full = out_valid_q && out_stall_i;

  // Memory port selection and pointer updates
  always_comb begin
    st_re    = cmd_i.rd_tid || cmd_i.rd_run || cmd_i.rd_idle;
    st_raddr = cmd_i.rd_tid ? tid_q[AW-1:0] : (cmd_i.rd_run ? run_q[AW-1:0] : idle_q[AW-1:0]);
    st_we    = 1'b0;
    st_waddr = tid_q[AW-1:0];
    st_wdata = ST_READY;
    q_we     = 1'b0;
    q_waddr  = tail;
    q_wdata  = tid_q;
    q_re     = cmd_i.rm_rd || cmd_i.qrd;
    q_raddr  = cmd_i.rm_rd ? pos_j : head_q;
    run_d    = run_q;
    head_d   = head_q;
    count_d  = count_q;
    j_d      = j_q;
    found_d  = found_q;
    ppos_d   = ppos_q;

    if (cmd_i.pre) begin
      st_we   = 1'b1;
      j_d     = '0;
      found_d = 1'b0;
      case (req_q)
        REQ_CREATE: begin
          q_we    = 1'b1;
          count_d = count_q + 1'b1;
        end
        REQ_UNBLOCK: begin
          q_we    = 1'b1;
          q_waddr = head_dec;
          head_d  = head_dec;
          count_d = count_q + 1'b1;
        end
        REQ_BLOCK: begin
          st_waddr = run_q[AW-1:0];
          st_wdata = blk_st;
        end
        default: begin
          st_wdata = ST_DEAD;
        end
      endcase
    end
    if (cmd_i.rm_ck) begin
      // shift later entries down one place once the slot is found
      if (found_q) begin
        q_we    = 1'b1;
        q_waddr = ppos_q;
        q_wdata = q_rdata_q;
      end else if (q_rdata_q == tid_q) begin
        found_d = 1'b1;
      end
      ppos_d = pos_j;
      j_d    = j_q + 1'b1;
      if (stat_o.rm_last) begin
        count_d = count_q - 1'b1;
      end
    end
    if (cmd_i.app) begin
      st_we    = 1'b1;
      st_waddr = run_q[AW-1:0];
      q_we     = 1'b1;
      q_wdata  = run_q;
      count_d  = count_q + 1'b1;
    end
    if (cmd_i.pop) begin
      st_we    = 1'b1;
      st_waddr = q_rdata_q[AW-1:0];
      st_wdata = ST_RUNNING;
      run_d    = q_rdata_q;
      head_d   = head_inc;
      count_d  = count_q - 1'b1;
    end
    if (cmd_i.wake) begin
      st_we    = 1'b1;
      st_waddr = idle_q[AW-1:0];
      st_wdata = ST_RUNNING;
      run_d    = idle_q;
    end
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      if (st_vld_q[st_raddr]) begin
        st_rdata_q <= st_mem[st_raddr];
      end else begin
        st_rdata_q <= (st_raddr == '0) ? ST_RUNNING : ST_DEAD;
      end
    end
    if (q_we) begin
      q_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rdata_q <= q_mem[q_raddr];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q    <= '0;
      idle_q      <= SLOT_W'(1);
      run_q       <= '0;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (st_we) begin
        st_vld_q[st_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        idle_q <= cfg_wdata_i;
      end
      run_q   <= run_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    j_q     <= j_d;
    found_q <= found_d;
    ppos_q  <= ppos_d;
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      tid_q  <= thread_id_i;
      kind_q <= block_kind_i;
      ns_q   <= need_schedule_i;
      prev_q <= run_q;
    end
    if (cmd_i.cap_t) begin
      s_t_q <= st_rdata_q;
    end
    if (cmd_i.cap_r) begin
      s_r_q <= st_rdata_q;
    end
    if (cmd_i.dec) begin
      plan_q <= plan_d;
    end
    if (cmd_i.out_load) begin
      out_err_q  <= plan_q.err;
      out_sw_q   <= plan_q.sw;
      out_prev_q <= prev_q;
      out_next_q <= run_q;
      out_cnt_q  <= 7'(count_q);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign error_code_o  = out_err_q;
  assign switched_o    = out_sw_q;
  assign prev_thread_o = out_prev_q;
  assign next_thread_o = out_next_q;
  assign ready_count_o = out_cnt_q;

endmodule

// ===== rtl/core/round_robin_thread_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler: round-robin ready-queue thread scheduler
// Keeps a status per thread slot, a ready deque and the running slot, and
// answers each request with one result item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one request item: create,
//   slice expiry, block, unblock, yield or exit. Output channel
//   (out_valid_o / out_stall_i) returns exactly one result item per request:
//   error code, switched flag, previous and next running slot, queue depth.
//   Write idle_slot through cfg_we_i / cfg_wdata_i while no request is open.
// Request processing:
//   A request steps from accept to result through the controller states; an
//   exit of a ready slot also walks the ready deque, reading and then
//   checking each queued entry in turn. One request is processed at a time;
//   the next one is accepted in the cycle after the result hand-off.
// Reset:
//   Slot 0 runs, all other slots are dead, the deque is empty and idle_slot
//   is 1. Status memory is cleared by per-slot valid bits, no sweep needed.
// Stall:
//   A result waits in the output register while out_stall_i is high; the
//   next request is still accepted and processed, and held only at its own
//   hand-off until the waiting result is taken.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
  parameter int THREAD_SLOTS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [5:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] req_type_i,
  input  logic [5:0] thread_id_i,
  input  logic [1:0] block_kind_i,
  input  logic       need_schedule_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] error_code_o,
  output logic       switched_o,
  output logic [5:0] prev_thread_o,
  output logic [5:0] next_thread_o,
  output logic [6:0] ready_count_o
);
  import rrts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence each request through the datapath
  rrts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold slot status, ready deque and the result register
  rrts_dp #(
    .THREAD_SLOTS (THREAD_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_type_i      (req_type_i),
    .thread_id_i     (thread_id_i),
    .block_kind_i    (block_kind_i),
    .need_schedule_i (need_schedule_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .error_code_o    (error_code_o),
    .switched_o      (switched_o),
    .prev_thread_o   (prev_thread_o),
    .next_thread_o   (next_thread_o),
    .ready_count_o   (ready_count_o),
    .cmd_i           (cmd),
    .stat_o          (stat)
  );

endmodule
